// File: rtl/core/ewhd_pkg.sv
// Shared types, constants and the half-root table of the edge weight decay block.
// No dependencies.
`timescale 1ns / 1ps
package ewhd_pkg;

  localparam int EXP_BITS  = 8;
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] CNT_CAP = 17'd65536;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] CFG_DECAY_EN   = 3'd0;
  localparam logic [2:0] CFG_CHECK_INTV = 3'd1;
  localparam logic [2:0] CFG_FLOOR      = 3'd2;
  localparam logic [2:0] CFG_MAX        = 3'd3;
  localparam logic [2:0] CFG_HALF_LIFE  = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [31:0]        clock_now;
    logic [31:0]        edge_weight;
    logic [31:0]        edge_last_access;
    logic [31:0]        edge_use_count;
    logic signed [31:0] reinforce_amount;
    logic               pass_first;
    logic               pass_last;
  } ewhd_in_t;

  typedef struct packed {
    logic [31:0] new_weight;
    logic [31:0] new_last_access;
    logic [31:0] new_use_count;
    logic        pass_skipped;
    logic        stats_valid;
    logic [16:0] cnt_checked;
    logic [16:0] cnt_decayed;
    logic [16:0] cnt_floor;
    logic [47:0] weight_lost;
    logic [31:0] avg_before;
    logic [31:0] avg_after;
  } ewhd_out_t;

  typedef struct packed {
    logic        decay_en;
    logic [31:0] check_intv;
    logic [31:0] floor_w;
    logic [31:0] max_w;
    logic [31:0] half_life;
  } ewhd_cfg_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    ewhd_in_t    item;
    logic [31:0] pass_time;
    logic        pass_skip;  // pass did not open
    logic        skip;       // pass skipped or decay disabled now
  } ewhd_entry_t;

  // 2^(-2^-(m+1)) in Q0.32
  function automatic logic [31:0] half_root(input logic [2:0] m);
    logic [31:0] r;
    unique case (m)
      3'd0:    r = 32'd3037000500;
      3'd1:    r = 32'd3611622603;
      3'd2:    r = 32'd3938502376;
      3'd3:    r = 32'd4112874773;
      3'd4:    r = 32'd4202935003;
      3'd5:    r = 32'd4248701965;
      3'd6:    r = 32'd4271771997;
      default: r = 32'd4283353945;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/edge_weight_halflife_decay.sv
// Top level of the edge weight half-life decay block: configuration registers,
// front end, item queue and back end. Depends on ewhd_pkg, ewhd_front, ewhd_queue, ewhd_back.
`timescale 1ns / 1ps
// Edge records stream in one item at a time; each gives exactly one result item.
// Decay items that open a pass (pass_first) decide whether the pass runs; edges of a
// running pass decay toward floor_weight by 2^(-elapsed/half_life) and the item with
// pass_last carries the pass statistics. While decay is enabled, reinforce items add a
// signed amount and count a use. The front end classifies items and queues up to two
// ahead of the back end, so input is taken while a result waits on a stalled output.
// The back end takes one item at a time. A reinforce item goes straight to the result;
// decay items pass the statistics update, and a full decay first runs the 40-step
// radix-2 divider (elapsed*256 over the half-life) and 8 half-root multiply steps; the
// last item of a running pass that checked at least one edge also runs the two average
// dividers. A stalled output holds the result. No clearing pass follows reset.
module edge_weight_halflife_decay import ewhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ewhd_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ewhd_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  ewhd_cfg_t   cfg_r;
  logic        push, pop, q_full, q_empty;
  ewhd_entry_t push_data, pop_data;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_en   <= 1'b1;
      cfg_r.check_intv <= 32'd3600;
      cfg_r.floor_w    <= 32'd0;
      cfg_r.max_w      <= 32'd655360;
      cfg_r.half_life  <= 32'd604800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY_EN:   cfg_r.decay_en   <= cfg_wdata[0];
        CFG_CHECK_INTV: cfg_r.check_intv <= cfg_wdata;
        CFG_FLOOR:      cfg_r.floor_w    <= cfg_wdata;
        CFG_MAX:        cfg_r.max_w      <= cfg_wdata;
        CFG_HALF_LIFE:  cfg_r.half_life  <= cfg_wdata;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  ewhd_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_stall, .in_data,
    .q_full, .push, .push_data
  );

  ewhd_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .full(q_full), .empty(q_empty)
  );

  ewhd_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_empty, .q_data(pop_data), .pop,
    .out_valid, .out_stall, .out_data
  );

  // statistics only appear on a stats item
  a_stats_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stats_valid |->
      (out_data.cnt_checked == '0) && (out_data.weight_lost == '0))
    else $error("statistics on a non-stats item");

  // decayed edges are a subset of checked edges
  a_decayed_le_checked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cnt_decayed <= out_data.cnt_checked)
    else $error("cnt_decayed above cnt_checked");

  // a full queue must hold off input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall)
    else $error("queue full without stall");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
endmodule

// File: rtl/core/ewhd_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on ewhd_pkg.
`timescale 1ns / 1ps
module ewhd_queue import ewhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ewhd_entry_t push_data,
  input  logic        pop,
  output ewhd_entry_t pop_data,
  output logic        full,
  output logic        empty
);
  ewhd_entry_t mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/core/ewhd_front.sv
// Front end: accepts items, tracks the pass time and skip decision, queues entries.
// Depends on ewhd_pkg.
`timescale 1ns / 1ps
module ewhd_front import ewhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ewhd_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  ewhd_in_t    in_data,
  input  logic        q_full,
  output logic        push,
  output ewhd_entry_t push_data
);
  logic [31:0] prev_r, prev_nxt, cpt_r, cpt_nxt;
  logic        pskip_r, pskip_nxt;
  logic        opens;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign opens    = !in_data.kind && in_data.pass_first;

  always_comb begin
    prev_nxt  = prev_r;
    cpt_nxt   = cpt_r;
    pskip_nxt = pskip_r;
    if (opens) begin
      cpt_nxt   = in_data.clock_now;
      pskip_nxt = !cfg.decay_en || (in_data.clock_now < prev_r) ||
                  ((in_data.clock_now - prev_r) < cfg.check_intv);
      if (!pskip_nxt) prev_nxt = in_data.clock_now;
    end
    push_data.item      = in_data;
    push_data.pass_time = cpt_nxt;
    push_data.pass_skip = pskip_nxt;
    push_data.skip      = pskip_nxt || !cfg.decay_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      cpt_r   <= '0;
      pskip_r <= 1'b0;
    end else if (push) begin
      prev_r  <= prev_nxt;
      cpt_r   <= cpt_nxt;
      pskip_r <= pskip_nxt;
    end
  end
endmodule

// File: rtl/core/ewhd_back.sv
// Back end: reinforce and decay arithmetic, pass statistics, averages and the result register.
// Depends on ewhd_pkg.
`timescale 1ns / 1ps
module ewhd_back import ewhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ewhd_cfg_t   cfg,
  input  logic        q_empty,
  input  ewhd_entry_t q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output ewhd_out_t   out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_DIV, S_ROM, S_FAC, S_MUL, S_FIN, S_UPD, S_STAT, S_AVG, S_OUT
  } state_t;

  state_t      state_r;
  ewhd_entry_t e_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [39:0] quo_r;
  logic [32:0] acc_r;
  logic [16:0] fac_r;
  logic [48:0] prod_r;
  logic [31:0] nw_r, na_r, nc_r;
  logic [47:0] sb_r, sa_r, ls_r;
  logic [16:0] ck_r, dc_r, fc_r;
  logic [16:0] arb_r, ara_r;
  logic [47:0] aqb_r, aqa_r;

  // shared views
  logic [31:0] w, fl, mx;
  assign w  = e_r.item.edge_weight;
  assign fl = cfg.floor_w;
  assign mx = cfg.max_w;

  // restoring divide step, {e, 8'b0} / half_life
  logic [32:0] dt, dsub;
  logic        dge;
  assign dt   = {rem_r, quo_r[39]};
  assign dsub = dt - {1'b0, cfg.half_life};
  assign dge  = (dt >= {1'b0, cfg.half_life});

  // half-root multiply
  logic [2:0]  rm;
  logic [63:0] rprod;
  assign rm    = cnt_r[2:0];
  assign rprod = acc_r[31:0] * half_root(rm) + 64'h8000_0000;

  // factor from ROM product and integer shift
  logic [31:0] q;
  logic [32:0] accsh;
  logic [33:0] facr;
  assign q     = quo_r[39:8];
  assign accsh = acc_r >> q[5:0];
  assign facr  = {1'b0, accsh} + 34'h8000;

  // final clamp
  logic [33:0] dsum;
  assign dsum = {1'b0, prod_r[48:16]} + {2'b00, fl};

  // reinforce
  logic [33:0] rs;
  assign rs = {2'b00, w} + {{2{e_r.item.reinforce_amount[31]}}, e_r.item.reinforce_amount};

  // averages, two lanes
  logic [17:0] tb, ta;
  logic        gb, ga;
  assign tb = {arb_r, aqb_r[47]};
  assign ta = {ara_r, aqa_r[47]};
  assign gb = (tb >= {1'b0, ck_r});
  assign ga = (ta >= {1'b0, ck_r});

  function automatic logic [16:0] cnt_inc(input logic [16:0] c);
    return (c < CNT_CAP) ? c + 17'd1 : CNT_CAP;
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? SUM_MAX : s[47:0];
  endfunction

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign out_valid = (state_r == S_OUT);

  logic stats_on;
  assign stats_on = !e_r.item.kind && e_r.item.pass_last && !e_r.pass_skip;

  always_comb begin
    out_data.new_weight      = nw_r;
    out_data.new_last_access = na_r;
    out_data.new_use_count   = nc_r;
    out_data.pass_skipped    = !e_r.item.kind && e_r.skip;
    out_data.stats_valid     = !e_r.item.kind && e_r.item.pass_last;
    out_data.cnt_checked     = stats_on ? ck_r : '0;
    out_data.cnt_decayed     = stats_on ? dc_r : '0;
    out_data.cnt_floor       = stats_on ? fc_r : '0;
    out_data.weight_lost     = stats_on ? ls_r : '0;
    out_data.avg_before      = !stats_on ? '0 : (|aqb_r[47:32] ? '1 : aqb_r[31:0]);
    out_data.avg_after       = !stats_on ? '0 : (|aqa_r[47:32] ? '1 : aqa_r[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sb_r <= '0; sa_r <= '0; ls_r <= '0;
      ck_r <= '0; dc_r <= '0; fc_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            e_r     <= q_data;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (e_r.item.kind) begin
            if (cfg.decay_en) begin
              nw_r <= rs[33] ? 32'd0 : ((rs[32:0] > {1'b0, mx}) ? mx : rs[31:0]);
              na_r <= e_r.item.clock_now;
              nc_r <= e_r.item.edge_use_count + 32'd1;
            end else begin
              nw_r <= w;
              na_r <= e_r.item.edge_last_access;
              nc_r <= e_r.item.edge_use_count;
            end
            state_r <= S_OUT;
          end else begin
            nc_r <= e_r.item.edge_use_count;
            if (e_r.item.pass_first) begin
              sb_r <= '0; sa_r <= '0; ls_r <= '0;
              ck_r <= '0; dc_r <= '0; fc_r <= '0;
            end
            if (e_r.skip) begin
              nw_r    <= w;
              na_r    <= e_r.item.edge_last_access;
              state_r <= S_UPD;
            end else if (e_r.item.edge_last_access == 32'd0) begin
              // never accessed: stamp the pass time
              nw_r    <= w;
              na_r    <= e_r.pass_time;
              state_r <= S_UPD;
            end else begin
              na_r <= e_r.item.edge_last_access;
              if (e_r.item.edge_last_access >= e_r.pass_time) begin
                nw_r    <= (w > fl) ? w : fl;
                state_r <= S_UPD;
              end else if ((w <= fl) || (cfg.half_life == 32'd0)) begin
                nw_r    <= fl;
                state_r <= S_UPD;
              end else begin
                nw_r    <= w;
                rem_r   <= '0;
                quo_r   <= {e_r.pass_time - e_r.item.edge_last_access, 8'd0};
                cnt_r   <= '0;
                state_r <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          rem_r <= dge ? dsub[31:0] : dt[31:0];
          quo_r <= {quo_r[38:0], dge};
          if (cnt_r == 6'd39) begin
            cnt_r   <= '0;
            acc_r   <= 33'h1_0000_0000;
            state_r <= S_ROM;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_ROM: begin
          // index bit 7 pairs with the square root of one half
          if (quo_r[3'd7 - rm]) begin
            acc_r <= acc_r[32] ? {1'b0, half_root(rm)} : {1'b0, rprod[63:32]};
          end
          cnt_r <= cnt_r + 6'd1;
          if (rm == 3'd7) state_r <= S_FAC;
        end
        S_FAC: begin
          fac_r   <= (q >= 32'd33) ? 17'd0 : facr[32:16];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= (w - fl) * fac_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (dsum > {2'b00, mx}) begin
            nw_r <= (mx < fl) ? fl : mx;
          end else begin
            nw_r <= dsum[31:0];
          end
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (!e_r.skip) begin
            ck_r <= cnt_inc(ck_r);
            sb_r <= sat_add(sb_r, w);
            sa_r <= sat_add(sa_r, nw_r);
            if (nw_r < w) begin
              dc_r <= cnt_inc(dc_r);
              ls_r <= sat_add(ls_r, w - nw_r);
            end
            if (nw_r <= fl) fc_r <= cnt_inc(fc_r);
          end
          state_r <= S_STAT;
        end
        S_STAT: begin
          arb_r <= '0; ara_r <= '0;
          cnt_r <= '0;
          if (stats_on && (ck_r != 17'd0)) begin
            aqb_r   <= sb_r;
            aqa_r   <= sa_r;
            state_r <= S_AVG;
          end else begin
            aqb_r   <= '0;
            aqa_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_AVG: begin
          arb_r <= gb ? 17'(tb - {1'b0, ck_r}) : tb[16:0];
          ara_r <= ga ? 17'(ta - {1'b0, ck_r}) : ta[16:0];
          aqb_r <= {aqb_r[46:0], gb};
          aqa_r <= {aqa_r[46:0], ga};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd47) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/sv/tb_edge_weight_halflife_decay.sv
// Self-checking testbench of edge_weight_halflife_decay: directed and random edge items,
// random input gaps and output stalls, register phases. Depends on ewhd_pkg and the block.
`timescale 1ns / 1ps
module tb_edge_weight_halflife_decay;
  import ewhd_pkg::*;

  localparam logic KIND_DECAY     = 1'b0;
  localparam logic KIND_REINFORCE = 1'b1;
  localparam int   N_RANDOM       = 1420;
  localparam int   QUIET_FROM     = 1300;  // no idling after this many items
  localparam int   HOLD_AT        = 600;   // results seen before the long receiver hold
  localparam int   HOLD_CYCLES    = 400;

  // Decay expectation and statistics tracker; one expected result per accepted item.
  class decay_scoreboard;
    logic [63:0] en, intv, fl, mx, hl;
    logic [63:0] prev_time, cur_time;
    bit          skipping;
    logic [47:0] sum_bef, sum_aft, lost;
    logic [16:0] n_chk, n_dec, n_flr;
    ewhd_out_t   expected_q[$];
    int          errors, results, passes;
    logic [31:0] roots[8];

    function new();
      roots = '{32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
                32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945};
      en = 1; intv = 3600; fl = 0; mx = 655360; hl = 604800;
      prev_time = 0; cur_time = 0; skipping = 0;
      sum_bef = 0; sum_aft = 0; lost = 0; n_chk = 0; n_dec = 0; n_flr = 0;
      errors = 0; results = 0; passes = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_DECAY_EN:   en = val[0];
        CFG_CHECK_INTV: intv = val;
        CFG_FLOOR:      fl = val;
        CFG_MAX:        mx = val;
        CFG_HALF_LIFE:  hl = val;
        default: ;
      endcase
    endfunction

    function logic [16:0] bump(logic [16:0] c);
      return (c < CNT_CAP) ? c + 17'd1 : CNT_CAP;
    endfunction

    function logic [47:0] sat_add(logic [47:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {16'd0, a} + b;
      return (s > {16'd0, SUM_MAX}) ? SUM_MAX : s[47:0];
    endfunction

    // 2^(-e/hl) in Q16.16 via whole half-lives plus a root-product table
    function logic [63:0] factor(logic [63:0] e);
      logic [63:0] q, r, idx, acc;
      if (hl == 0) return 0;
      q = e / hl;
      r = e % hl;
      idx = (r << EXP_BITS) / hl;
      acc = 64'd1 << 32;
      for (int m = 0; m < EXP_BITS; m++)
        if (idx[EXP_BITS-1-m]) acc = (acc * roots[m] + (64'd1 << 31)) >> 32;
      if (q >= 33) return 0;
      acc = acc >> q;
      return (acc + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    endfunction

    function logic [63:0] decayed(logic [63:0] w, logic [63:0] last);
      logic [63:0] d;
      if (last >= cur_time) return (w > fl) ? w : fl;
      if (w <= fl) return fl;
      d = (((w - fl) * factor(cur_time - last)) >> FRAC_BITS) + fl;
      if (d > mx) d = mx;
      if (d < fl) d = fl;
      return d;
    endfunction

    function void note(ewhd_in_t x);
      ewhd_out_t   o;
      logic [63:0] w, last, nw, na, nc, ab, aa;
      longint      s;
      bit          skip;
      o = '0;
      w = x.edge_weight; last = x.edge_last_access;
      nw = w; na = last; nc = x.edge_use_count;
      if (x.kind == KIND_REINFORCE) begin
        if (en[0]) begin
          s = longint'(w) + longint'($signed(x.reinforce_amount));
          if (s < 0) s = 0;
          if (s > longint'(mx)) s = longint'(mx);
          nw = s;
          na = x.clock_now;
          nc = {32'd0, x.edge_use_count + 32'd1};
        end
      end else begin
        if (x.pass_first) begin
          passes++;
          cur_time = x.clock_now;
          skipping = !en[0] || (cur_time < prev_time) || (cur_time - prev_time < intv);
          if (!skipping) prev_time = cur_time;
          sum_bef = 0; sum_aft = 0; lost = 0; n_chk = 0; n_dec = 0; n_flr = 0;
        end
        skip = skipping || !en[0];
        if (!skip) begin
          if (last == 0) na = cur_time;
          else nw = decayed(w, last);
          n_chk = bump(n_chk);
          sum_bef = sat_add(sum_bef, w);
          sum_aft = sat_add(sum_aft, nw);
          if (nw < w) begin
            n_dec = bump(n_dec);
            lost = sat_add(lost, w - nw);
          end
          if (nw <= fl) n_flr = bump(n_flr);
        end
        o.pass_skipped = skip;
        if (x.pass_last) begin
          o.stats_valid = 1'b1;
          if (!skipping) begin
            ab = 0; aa = 0;
            if (n_chk != 0) begin
              ab = sum_bef / n_chk;
              aa = sum_aft / n_chk;
            end
            o.cnt_checked = n_chk;
            o.cnt_decayed = n_dec;
            o.cnt_floor   = n_flr;
            o.weight_lost = lost;
            o.avg_before  = (ab > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ab[31:0];
            o.avg_after   = (aa > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : aa[31:0];
          end
        end
      end
      o.new_weight = nw[31:0];
      o.new_last_access = na[31:0];
      o.new_use_count = nc[31:0];
      expected_q.push_back(o);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $error("%s mismatch: expected %0h, got %0h", name, e, a);
      end
    endfunction

    function void check(ewhd_out_t got);
      ewhd_out_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result item with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      cmp("new_weight", e.new_weight, got.new_weight);
      cmp("new_last_access", e.new_last_access, got.new_last_access);
      cmp("new_use_count", e.new_use_count, got.new_use_count);
      cmp("pass_skipped", e.pass_skipped, got.pass_skipped);
      cmp("stats_valid", e.stats_valid, got.stats_valid);
      cmp("cnt_checked", e.cnt_checked, got.cnt_checked);
      cmp("cnt_decayed", e.cnt_decayed, got.cnt_decayed);
      cmp("cnt_floor", e.cnt_floor, got.cnt_floor);
      cmp("weight_lost", e.weight_lost, got.weight_lost);
      cmp("avg_before", e.avg_before, got.avg_before);
      cmp("avg_after", e.avg_after, got.avg_after);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ewhd_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ewhd_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  decay_scoreboard sb = new();
  int  n_sent = 0;
  bit  quiet = 0;
  logic [31:0] clock_s = 32'd10000;  // running clock time of the stimulus

  edge_weight_halflife_decay i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one item, hold it until taken, then maybe leave a gap.
  task automatic send_item(ewhd_in_t x);
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(x);
    n_sent++;
    if (n_sent >= QUIET_FROM) quiet = 1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic ewhd_in_t mk(logic k, logic [31:0] now, logic [31:0] w,
                                  logic [31:0] last, logic [31:0] cnt, logic [31:0] amt,
                                  logic f, logic l);
    ewhd_in_t x;
    x.kind = k; x.clock_now = now; x.edge_weight = w; x.edge_last_access = last;
    x.edge_use_count = cnt; x.reinforce_amount = amt; x.pass_first = f; x.pass_last = l;
    return x;
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return sb.fl[31:0] + $urandom_range(0, 3);
      3:       return sb.mx[31:0];
      default: return $urandom >> $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_last(logic [31:0] now);
    case ($urandom_range(0, 7))
      0:       return 32'd0;                      // never accessed
      1:       return now + $urandom_range(0, 5); // no time elapsed
      2:       return $urandom;
      default: return now - (($urandom >> $urandom_range(0, 31)) + 1);
    endcase
  endfunction

  function automatic ewhd_in_t reinforce_item();
    logic [31:0] amt;
    case ($urandom_range(0, 3))
      0:       amt = $urandom;
      1:       amt = 32'h7FFF_FFFF;
      2:       amt = 32'h8000_0000;
      default: amt = $urandom_range(0, 32'h3_0000) - 32'h1_8000;
    endcase
    return mk(KIND_REINFORCE, clock_s, pick_weight(), $urandom, $urandom, amt,
              $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  // One decay pass of 1..8 edges with reinforce items mixed in.
  task automatic send_pass(int n_edges);
    logic [31:0] now;
    case ($urandom_range(0, 5))
      0:       clock_s = clock_s + $urandom_range(0, 100);
      1:       clock_s = clock_s - $urandom_range(0, 1000);  // may fall before last pass
      2:       clock_s = $urandom;
      default: clock_s = clock_s + sb.intv[31:0] + $urandom_range(0, 100000);
    endcase
    now = clock_s;
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 4) == 0) send_item(reinforce_item());
      send_item(mk(KIND_DECAY, (i == 0) ? now : $urandom, pick_weight(), pick_last(now),
                   $urandom, $urandom, i == 0, i == n_edges - 1));
    end
  endtask

  function automatic logic [31:0] pick_cfg(int phase, logic [31:0] lo, logic [31:0] hi,
                                           logic [31:0] typ);
    if (phase == 0) return lo;
    if (phase == 1) return hi;
    case ($urandom_range(0, 3))
      0:       return typ;
      1:       return $urandom;
      2:       return $urandom_range(0, 32'h40000);
      default: return (phase % 2) ? hi : lo;
    endcase
  endfunction

  // Result side: random stall bursts plus one long hold, started while items are offered.
  initial begin
    int burst, hold_left;
    bit held;
    burst = 0; hold_left = 0; held = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check(out_data);
      if (!held && sb.results >= HOLD_AT && in_valid) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, first pass runs since time zero.
    send_item(mk(KIND_DECAY, 32'd10000, 32'h0001_0000, 32'd0, 32'd5, 32'd0, 1, 0));
    send_item(mk(KIND_DECAY, 32'd0, 32'hFFFF_FFFF, 32'd9000, 32'd0, 32'd0, 0, 0));
    send_item(mk(KIND_DECAY, 32'd0, 32'h0005_0000, 32'd10000, 32'd0, 32'd0, 0, 0));
    send_item(mk(KIND_DECAY, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 0, 0));
    send_item(mk(KIND_DECAY, 32'd0, 32'h000A_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 0, 1));
    send_item(mk(KIND_REINFORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 1, 1));
    send_item(mk(KIND_REINFORCE, 32'd20000, 32'h0001_0000, 32'd0, 32'd7, 32'h8000_0000, 0, 0));
    send_item(mk(KIND_REINFORCE, 32'd20000, 32'h0002_0000, 32'd3, 32'd0, 32'hFFFF_8000, 0, 0));
    // too soon after the previous pass: skipped
    send_item(mk(KIND_DECAY, 32'd10001, 32'h0003_0000, 32'd5000, 32'd1, 32'd0, 1, 1));
    // clock before the previous pass: skipped
    send_item(mk(KIND_DECAY, 32'd5, 32'h0003_0000, 32'd1, 32'd1, 32'd0, 1, 0));
    send_item(mk(KIND_DECAY, 32'd5, 32'h0003_0000, 32'd0, 32'd1, 32'd0, 0, 1));
    // decay items outside a marked pass, around a one-item pass at the largest clock
    send_item(mk(KIND_DECAY, 32'd99, 32'h0004_0000, 32'd2, 32'd1, 32'd0, 0, 0));
    send_item(mk(KIND_DECAY, 32'hFFFF_FFFF, 32'h0006_0000, 32'd0, 32'd0, 32'd0, 1, 1));
    send_item(mk(KIND_DECAY, 32'd0, 32'h0006_0000, 32'd1, 32'd0, 32'd0, 0, 1));
    drain();
    // floor above max, zero half-life, then disabled within an open pass
    write_reg(CFG_FLOOR, 32'h000B_0000);
    write_reg(CFG_MAX, 32'h0002_0000);
    write_reg(CFG_HALF_LIFE, 32'd0);
    write_reg(CFG_CHECK_INTV, 32'd0);
    send_item(mk(KIND_DECAY, 32'd70000, 32'h000F_0000, 32'd100, 32'd0, 32'd0, 1, 0));
    send_item(mk(KIND_DECAY, 32'd0, 32'h0001_0000, 32'd100, 32'd0, 32'd0, 0, 0));
    drain();
    write_reg(CFG_DECAY_EN, 32'd0);
    send_item(mk(KIND_DECAY, 32'd0, 32'h0009_0000, 32'd100, 32'd0, 32'd0, 0, 1));
    send_item(mk(KIND_REINFORCE, 32'd9, 32'h0009_0000, 32'd100, 32'd3, 32'h0001_0000, 0, 0));
    drain();

    // Random phases, each with its own register settings.
    phase = 0;
    while (n_sent < N_RANDOM) begin
      write_reg(CFG_DECAY_EN, (phase < 2 || $urandom_range(0, 5) != 0) ? 32'd1 : 32'd0);
      write_reg(CFG_CHECK_INTV, pick_cfg(phase, 32'd0, 32'hFFFF_FFFF, 32'd3600));
      write_reg(CFG_FLOOR, pick_cfg(phase, 32'd0, 32'hFFFF_FFFF, 32'h0000_8000));
      write_reg(CFG_MAX, pick_cfg(phase, 32'd0, 32'hFFFF_FFFF, 32'd655360));
      write_reg(CFG_HALF_LIFE, pick_cfg(phase, 32'd1, 32'hFFFF_FFFF, 32'd604800));
      if (phase < 2) write_reg(CFG_FLOOR, 32'd0);  // keep the extreme phases decaying
      for (int k = 0; k < 20 && n_sent < N_RANDOM; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(mk($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
        else
          send_pass($urandom_range(1, 8));
      end
      drain();
      phase++;
    end

    drain();
    $display("covered %0d items in %0d passes over %0d register phases, %0d results checked",
             n_sent, sb.passes, phase, sb.results);
    $display("included a %0d-cycle output hold with the input still offered", HOLD_CYCLES);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ewhd_pkg.sv
rtl/core/ewhd_queue.sv
rtl/core/ewhd_front.sv
rtl/core/ewhd_back.sv
rtl/core/edge_weight_halflife_decay.sv
tb/sv/tb_edge_weight_halflife_decay.sv
